/* sv/bsc_pkg.sv */
package bsc_pkg;

  localparam int unsigned RAW_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned PIPE_DEPTH = 84;
  localparam int unsigned TEMP_DLY   = 80;
  localparam int unsigned RAWP_DLY   = 9;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] P_FULL      = 64'd1048576;
  localparam logic [63:0] P_SCALE     = 64'd3125;
  localparam logic [63:0] P_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic [31:0] T_ROUND     = 32'd128;
  localparam logic [31:0] T_SCALE     = 32'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_TRIM    = 2'd0,
    CFG_PRESS_TRIM_A = 2'd1,
    CFG_PRESS_TRIM_B = 2'd2,
    CFG_PRESS_TRIM_C = 2'd3
  } bsc_cfg_e;

  typedef struct packed {
    logic neg;
    logic dz;
  } bsc_side_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

/* sv/bsc_if.sv */
interface bsc_in_if;
  logic                     valid;
  logic                     ready;
  logic [bsc_pkg::RAW_W-1:0] raw_temperature;
  logic [bsc_pkg::RAW_W-1:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               divisor_zero;

  modport source (output valid, temperature_centi, pressure_q24_8, divisor_zero,
                  input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, divisor_zero,
                  output ready);
endinterface

/* sv/bsc_mul64.sv */
module bsc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);
  import bsc_pkg::*;

  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_d, lh_q, hl_d, hl_q;
  logic [63:0] p_d, p_q;

  // low 64 bits of the product from three 32x32 partials
  assign ll_d = a_i[31:0] * b_i[31:0];
  assign lh_d = a_i[31:0] * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];
  assign p_d  = ll_q + {lh_q + hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* sv/bsc_div.sv */
module bsc_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [63:0]        num_i,
  input  logic [63:0]        den_i,
  input  bsc_pkg::bsc_side_t side_i,
  output logic [63:0]        q_o,
  output bsc_pkg::bsc_side_t side_o
);
  import bsc_pkg::*;

  logic [63:0] rem_q  [DIV_STEPS+1];
  logic [63:0] nq_q   [DIV_STEPS+1];
  logic [63:0] den_q  [DIV_STEPS+1];
  bsc_side_t   side_q [DIV_STEPS+1];
  logic [63:0] q_q;
  bsc_side_t   side_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= 64'd0;
      nq_q[0]   <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q[0]  <= den_i[63] ? (64'd0 - den_i) : den_i;
      side_q[0] <= side_i;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] trial;
    logic        fits;
    assign trial = {rem_q[k], nq_q[k][63]};
    assign fits  = trial >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= fits ? 64'(trial - {1'b0, den_q[k]}) : trial[63:0];
        nq_q[k+1]   <= {nq_q[k][62:0], fits};
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q        <= side_q[DIV_STEPS].neg ? (64'd0 - nq_q[DIV_STEPS]) : nq_q[DIV_STEPS];
      side_out_q <= side_q[DIV_STEPS];
    end
  end

  assign q_o    = q_q;
  assign side_o = side_out_q;

endmodule

/* sv/barometric_sensor_compensation_top.sv */
// Barometric compensation pipeline.
// Input channel in_s carries one raw temperature and one raw pressure
// reading per transfer; output channel out_s carries temperature in
// 0.01 degC, pressure in Pa as Q24.8 and a divisor-zero flag.
// Trim words are written through cfg_we_i/cfg_idx_i/cfg_data_i; users
// must write them only while the pipeline is empty, which the block does
// not enforce; they feed the stages that use them directly.
// Throughput: one transfer per cycle unless the output stalls. The delay
// is set mainly by the 64-stage radix-2 divider and 64-bit multipliers.
// Reset clears the trim registers and all stage valid bits; the pipeline
// comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and in_s.ready drops; nothing is dropped or duplicated, and
// empty stages fill while the output is not valid.
module barometric_sensor_compensation_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bsc_in_if.sink                          in_s,
  bsc_out_if.source                       out_s
);
  import bsc_pkg::*;

  logic [47:0] temp_trim_q;
  logic [63:0] press_trim_a_q, press_trim_b_q;
  logic [15:0] press_trim_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q    <= '0;
      press_trim_a_q <= '0;
      press_trim_b_q <= '0;
      press_trim_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bsc_cfg_e'(cfg_idx_i))
        CFG_TEMP_TRIM:    temp_trim_q    <= cfg_data_i[47:0];
        CFG_PRESS_TRIM_A: press_trim_a_q <= cfg_data_i;
        CFG_PRESS_TRIM_B: press_trim_b_q <= cfg_data_i;
        CFG_PRESS_TRIM_C: press_trim_c_q <= cfg_data_i[15:0];
        default:          ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, temp_trim_q[15:0]};
  assign t2 = {{16{temp_trim_q[31]}}, temp_trim_q[31:16]};
  assign t3 = {{16{temp_trim_q[47]}}, temp_trim_q[47:32]};
  assign p1 = {48'd0, press_trim_a_q[15:0]};
  assign p2 = sx16(press_trim_a_q[31:16]);
  assign p3 = sx16(press_trim_a_q[47:32]);
  assign p4 = sx16(press_trim_a_q[63:48]);
  assign p5 = sx16(press_trim_b_q[15:0]);
  assign p6 = sx16(press_trim_b_q[31:16]);
  assign p7 = sx16(press_trim_b_q[47:32]);
  assign p8 = sx16(press_trim_b_q[63:48]);
  assign p9 = sx16(press_trim_c_q);

  // global stall
  logic                  en;
  logic [PIPE_DEPTH-1:0] v_q;

  assign en         = !v_q[PIPE_DEPTH-1] || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_s.valid};
    end
  end

  // temperature path
  logic [31:0] d1, d2, m1_q, m2_q, v1_q, m3_q, fine_q, f5, tc_q;
  logic [31:0] tcd_q [TEMP_DLY];
  logic [RAW_W-1:0] rawp_q [RAWP_DLY];

  assign d1 = 32'(in_s.raw_temperature[RAW_W-1:3]) - {t1[30:0], 1'b0};
  assign d2 = 32'(in_s.raw_temperature[RAW_W-1:4]) - t1;
  assign f5 = fine_q * T_SCALE + T_ROUND;

  // pressure path
  logic [63:0] a_q, aa, ap5, ap2, b1, x, y, num, ph;
  logic [63:0] ap5_q [2];
  logic [63:0] ap2_q [2];
  logic [63:0] b_q, a3_q, nb_q, den_q, pr;
  logic [63:0] q, pa, pb, pc;
  logic [63:0] ph_q [2];
  logic [63:0] pb_q [2];
  logic [63:0] qd_q [4];
  logic [63:0] s_q;
  logic [31:0] press_q;
  bsc_side_t   side, dside;
  bsc_side_t   side_q [6];

  assign pr = P_FULL - 64'(rawp_q[RAWP_DLY-1]);
  assign ph = $signed(q) >>> 13;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= d1 * t2;
      m2_q   <= d2 * d2;
      v1_q   <= $signed(m1_q) >>> 11;
      m3_q   <= 32'($signed(m2_q) >>> 12) * t3;
      fine_q <= v1_q + 32'($signed(m3_q) >>> 14);
      tc_q   <= $signed(f5) >>> 8;
      a_q    <= {{32{fine_q[31]}}, fine_q} - FINE_OFFSET;

      tcd_q[0] <= tc_q;
      for (int i = 1; i < TEMP_DLY; i++) tcd_q[i] <= tcd_q[i-1];
      rawp_q[0] <= in_s.raw_pressure;
      for (int i = 1; i < RAWP_DLY; i++) rawp_q[i] <= rawp_q[i-1];

      ap5_q[0] <= ap5;
      ap5_q[1] <= ap5_q[0];
      ap2_q[0] <= ap2;
      ap2_q[1] <= ap2_q[0];

      b_q   <= b1 + (ap5_q[1] << 17) + (p4 << 35);
      a3_q  <= 64'($signed(x) >>> 8) + (ap2_q[1] << 12) + P_BIAS;
      nb_q  <= (pr << 31) - b_q;
      den_q <= $signed(y) >>> 33;

      ph_q[0] <= ph;
      ph_q[1] <= ph_q[0];
      pb_q[0] <= pb;
      pb_q[1] <= pb_q[0];
      qd_q[0] <= q;
      for (int i = 1; i < 4; i++) qd_q[i] <= qd_q[i-1];
      side_q[0] <= dside;
      for (int i = 1; i < 6; i++) side_q[i] <= side_q[i-1];

      s_q     <= qd_q[3] + 64'($signed(pc) >>> 25) + 64'($signed(pb_q[1]) >>> 19);
      press_q <= side_q[4].dz ? 32'd0 : 32'(64'($signed(s_q) >>> 8) + (p7 << 4));
    end
  end

  bsc_mul64 u_mul_aa  (.clk_i, .en_i(en), .a_i(a_q),  .b_i(a_q), .p_o(aa));
  bsc_mul64 u_mul_ap5 (.clk_i, .en_i(en), .a_i(a_q),  .b_i(p5),  .p_o(ap5));
  bsc_mul64 u_mul_ap2 (.clk_i, .en_i(en), .a_i(a_q),  .b_i(p2),  .p_o(ap2));
  bsc_mul64 u_mul_b1  (.clk_i, .en_i(en), .a_i(aa),   .b_i(p6),  .p_o(b1));
  bsc_mul64 u_mul_x   (.clk_i, .en_i(en), .a_i(aa),   .b_i(p3),  .p_o(x));
  bsc_mul64 u_mul_y   (.clk_i, .en_i(en), .a_i(a3_q), .b_i(p1),  .p_o(y));
  bsc_mul64 u_mul_num (.clk_i, .en_i(en), .a_i(nb_q), .b_i(P_SCALE), .p_o(num));

  assign side.neg = num[63] ^ den_q[63];
  assign side.dz  = den_q == 64'd0;

  bsc_div u_div (
    .clk_i,
    .en_i   (en),
    .num_i  (num),
    .den_i  (den_q),
    .side_i (side),
    .q_o    (q),
    .side_o (dside)
  );

  bsc_mul64 u_mul_pa (.clk_i, .en_i(en), .a_i(p9), .b_i(ph),      .p_o(pa));
  bsc_mul64 u_mul_pb (.clk_i, .en_i(en), .a_i(p8), .b_i(q),       .p_o(pb));
  bsc_mul64 u_mul_pc (.clk_i, .en_i(en), .a_i(pa), .b_i(ph_q[1]), .p_o(pc));

  assign out_s.valid             = v_q[PIPE_DEPTH-1];
  assign out_s.temperature_centi = tcd_q[TEMP_DLY-1];
  assign out_s.pressure_q24_8    = press_q;
  assign out_s.divisor_zero      = side_q[5].dz;

endmodule
